FILE: src/segpwm_pkg.sv
package segpwm_pkg;

    localparam int unsigned STRING_DEPTH_DEF = 16;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned SYM_W    = 6;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned SEG_W    = 7;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned TICK_W   = 8;
    localparam int unsigned PCT_W    = 7;
    localparam int unsigned PROD_W   = PERIOD_W + PCT_W;
    localparam int unsigned RECIP_W  = 24;
    localparam int unsigned RECIP_SH = 30;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [RECIP_W-1:0] DIV100_RECIP = 24'd10737419;

    localparam logic [CMD_W-1:0] CMD_PWM    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SYMBOL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ENABLE = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH  = 3'd6;

    localparam logic [SYM_W-1:0] SYM_BLANK = 6'd38;
    localparam logic [SYM_W-1:0] SYM_END   = 6'd39;

    localparam logic [SEG_W-1:0] SEG_OFF = 7'h7F;

    localparam logic [PCT_W-1:0] PCT_MIN = 7'd1;
    localparam logic [PCT_W-1:0] PCT_MAX = 7'd99;

    function automatic logic [SEG_W-1:0] decode_glyph(input logic [SYM_W-1:0] sym);
        logic [SEG_W-1:0] lit;
        case (sym)
            6'd0:  lit = 7'h3F;
            6'd1:  lit = 7'h06;
            6'd2:  lit = 7'h5B;
            6'd3:  lit = 7'h4F;
            6'd4:  lit = 7'h66;
            6'd5:  lit = 7'h6D;
            6'd6:  lit = 7'h7D;
            6'd7:  lit = 7'h07;
            6'd8:  lit = 7'h7F;
            6'd9:  lit = 7'h6F;
            6'd10: lit = 7'h77;
            6'd11: lit = 7'h7C;
            6'd12: lit = 7'h39;
            6'd13: lit = 7'h5E;
            6'd14: lit = 7'h79;
            6'd15: lit = 7'h71;
            6'd16: lit = 7'h3E;
            6'd17: lit = 7'h38;
            6'd18: lit = 7'h73;
            6'd19: lit = 7'h50;
            6'd20: lit = 7'h54;
            6'd21: lit = 7'h5C;
            6'd22: lit = 7'h30;
            6'd23: lit = 7'h0E;
            6'd24: lit = 7'h6E;
            6'd25: lit = 7'h78;
            6'd26: lit = 7'h76;
            6'd27: lit = 7'h01;
            6'd28: lit = 7'h02;
            6'd29: lit = 7'h04;
            6'd30: lit = 7'h08;
            6'd31: lit = 7'h10;
            6'd32: lit = 7'h20;
            6'd33: lit = 7'h40;
            6'd34: lit = 7'h03;
            6'd35: lit = 7'h0F;
            6'd36: lit = 7'h1F;
            6'd37: lit = 7'h5D;
            6'd38: lit = 7'h00;
            6'd39: lit = 7'h7F;
            default: lit = 7'h00;
        endcase
        return ~lit;
    endfunction

endpackage

FILE: src/seven_segment_string_pwm_driver.sv
// Each item is registered in the product, divide and state-update stages.
// Throughput: one item per cycle unless stalled; the three-stage pipeline
// (product, divide by 100 through a reciprocal multiply, state update) keeps
// moving while a result waits, collapsing bubbles before it stalls the input.
// Reset (synchronous, active low) clears control state and restores register
// defaults; the string store is not cleared and is undefined until written.
module seven_segment_string_pwm_driver
    import segpwm_pkg::*;
#(
    parameter int unsigned STRING_DEPTH = STRING_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [SYM_W-1:0]      i_symbol,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic                  i_enable_value,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SEG_W-1:0]      o_segments_n,
    output logic                  o_flash_out,
    output logic [PERIOD_W-1:0]   o_next_interval,
    output logic                  o_string_active,
    output logic [SYM_W-1:0]      o_shown_symbol
);

    localparam int unsigned POS_W = (STRING_DEPTH > 1) ? $clog2(STRING_DEPTH) : 1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] entry_index;
        logic             enable_value;
    } t_item;

    // configuration
    logic [PERIOD_W-1:0] r_pwm_period;
    logic [TICK_W-1:0]   r_brightness;
    logic [TICK_W-1:0]   r_char_ticks;
    logic [TICK_W-1:0]   r_space_ticks;
    logic [TICK_W-1:0]   r_end_ticks;
    logic                r_loop_enable;
    logic                r_flash_enable;

    // pipeline
    logic                r_v1, r_v2, r_v3;
    t_item               r_item1, r_item2;
    logic [PROD_W-1:0]   r_prod1;
    logic [PERIOD_W-1:0] r_on2;
    logic                ready1, ready2, ready3;
    logic                adv1, adv2, adv3;

    // block state
    logic                r_display_on, n_display_on;
    logic                r_pwm_phase, n_pwm_phase;
    logic                r_string_mode, n_string_mode;
    logic [SYM_W-1:0]    r_current_symbol, n_current_symbol;
    logic [POS_W-1:0]    r_string_position, n_string_position;
    logic                r_in_gap, n_in_gap;
    logic [TICK_W-1:0]   r_ticks_left, n_ticks_left;
    logic [SEG_W-1:0]    r_segment_pins, n_segment_pins;
    logic                r_flash_pin, n_flash_pin;
    logic [SYM_W-1:0]    r_store [STRING_DEPTH];

    logic [PERIOD_W-1:0] r_interval, n_interval;

    logic [PCT_W-1:0]          pct;
    logic [PROD_W+RECIP_W-1:0] quot_full;
    logic [PERIOD_W-1:0]       off_time;
    logic [POS_W:0]            nxt;
    logic                      nxt_in_range;
    logic [SYM_W-1:0]          nxt_sym;
    logic                      nxt_is_end;
    logic                      do_next;
    logic [TICK_W-1:0]         tick_dec;
    logic [TICK_W-1:0]         gap_len;
    logic                      widx_ok;

    assign ready3 = !r_v3 || !i_out_stall;
    assign ready2 = !r_v2 || ready3;
    assign ready1 = !r_v1 || ready2;
    assign adv1   = i_in_valid && ready1;
    assign adv2   = r_v1 && ready2;
    assign adv3   = r_v2 && ready3;
    assign o_in_stall = !ready1;

    always_comb begin
        pct = r_brightness[PCT_W-1:0];
        if (r_brightness > TICK_W'(PCT_MAX)) begin
            pct = PCT_MAX;
        end else if (r_brightness < TICK_W'(PCT_MIN)) begin
            pct = PCT_MIN;
        end
    end

    assign quot_full = (PROD_W+RECIP_W)'(r_prod1) * (PROD_W+RECIP_W)'(DIV100_RECIP);
    assign off_time  = r_pwm_period - r_on2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_in_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_item1.cmd          <= i_cmd;
            r_item1.symbol       <= i_symbol;
            r_item1.entry_index  <= i_entry_index;
            r_item1.enable_value <= i_enable_value;
            r_prod1 <= PROD_W'(r_pwm_period) * PROD_W'(pct);
        end
        if (adv2) begin
            r_item2 <= r_item1;
            r_on2   <= quot_full[RECIP_SH +: PERIOD_W];
        end
    end

    always_comb begin
        nxt          = {1'b0, r_string_position} + (POS_W+1)'(1);
        nxt_in_range = 32'(nxt) < STRING_DEPTH;
        nxt_sym      = nxt_in_range ? r_store[nxt[POS_W-1:0]] : SYM_END;
        nxt_is_end   = nxt_sym == SYM_END;
        widx_ok      = 32'(r_item2.entry_index) < STRING_DEPTH;
    end

    always_comb begin
        n_display_on      = r_display_on;
        n_pwm_phase       = r_pwm_phase;
        n_string_mode     = r_string_mode;
        n_current_symbol  = r_current_symbol;
        n_string_position = r_string_position;
        n_in_gap          = r_in_gap;
        n_ticks_left      = r_ticks_left;
        n_segment_pins    = r_segment_pins;
        n_flash_pin       = r_flash_pin;
        n_interval        = '0;
        do_next           = 1'b0;
        tick_dec          = r_ticks_left - TICK_W'(1);
        gap_len           = nxt_is_end ? r_end_ticks : r_space_ticks;

        case (r_item2.cmd)
            CMD_PWM: begin
                n_pwm_phase = !r_pwm_phase;
                if (r_flash_enable) begin
                    if (!r_pwm_phase) begin
                        n_flash_pin = 1'b1;
                        if (r_display_on) begin
                            n_segment_pins = decode_glyph(r_current_symbol);
                        end
                        n_interval = r_on2;
                    end else begin
                        n_flash_pin = 1'b0;
                        n_interval  = off_time;
                    end
                end else if (!r_display_on) begin
                    n_interval = r_pwm_period;
                end else if (!r_pwm_phase) begin
                    n_segment_pins = decode_glyph(r_current_symbol);
                    n_interval     = r_on2;
                end else begin
                    n_segment_pins = SEG_OFF;
                    n_interval     = off_time;
                end
            end
            CMD_TICK: begin
                if (r_string_mode && r_display_on) begin
                    n_ticks_left = tick_dec;
                    if (tick_dec == '0) begin
                        if (r_in_gap) begin
                            do_next = 1'b1;
                        end else begin
                            n_ticks_left = gap_len;
                            if (gap_len == '0) begin
                                do_next = 1'b1;
                            end else begin
                                n_in_gap         = 1'b1;
                                n_current_symbol = SYM_BLANK;
                            end
                        end
                    end
                end
            end
            CMD_START: begin
                if (r_display_on) begin
                    n_string_position = '0;
                    n_in_gap          = 1'b0;
                    n_ticks_left      = r_char_ticks;
                    n_current_symbol  = r_store[0];
                    n_string_mode     = 1'b1;
                end
            end
            CMD_SYMBOL: begin
                n_current_symbol = r_item2.symbol;
                n_string_mode    = 1'b0;
            end
            CMD_ENABLE: begin
                n_display_on   = r_item2.enable_value;
                n_string_mode  = 1'b0;
                n_segment_pins = r_item2.enable_value ? decode_glyph(r_current_symbol)
                                                      : SEG_OFF;
            end
            default: begin
            end
        endcase

        if (do_next) begin
            n_ticks_left = r_char_ticks;
            n_in_gap     = 1'b0;
            if (nxt_is_end) begin
                if (r_loop_enable) begin
                    n_string_position = '0;
                    n_current_symbol  = r_store[0];
                end else begin
                    n_string_position = nxt_in_range ? nxt[POS_W-1:0] : '0;
                    n_current_symbol  = SYM_BLANK;
                    n_string_mode     = 1'b0;
                end
            end else begin
                n_string_position = nxt[POS_W-1:0];
                n_current_symbol  = nxt_sym;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_on      <= 1'b0;
            r_pwm_phase       <= 1'b0;
            r_string_mode     <= 1'b0;
            r_current_symbol  <= SYM_BLANK;
            r_string_position <= '0;
            r_in_gap          <= 1'b0;
            r_ticks_left      <= '0;
            r_segment_pins    <= SEG_OFF;
            r_flash_pin       <= 1'b0;
            r_pwm_period      <= 16'd1000;
            r_brightness      <= 8'd50;
            r_char_ticks      <= 8'd10;
            r_space_ticks     <= 8'd2;
            r_end_ticks       <= 8'd20;
            r_loop_enable     <= 1'b0;
            r_flash_enable    <= 1'b0;
        end else begin
            if (adv3) begin
                r_display_on      <= n_display_on;
                r_pwm_phase       <= n_pwm_phase;
                r_string_mode     <= n_string_mode;
                r_current_symbol  <= n_current_symbol;
                r_string_position <= n_string_position;
                r_in_gap          <= n_in_gap;
                r_ticks_left      <= n_ticks_left;
                r_segment_pins    <= n_segment_pins;
                r_flash_pin       <= n_flash_pin;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PERIOD: r_pwm_period  <= i_cfg_data;
                    REG_BRIGHT: r_brightness  <= i_cfg_data[TICK_W-1:0];
                    REG_CHAR:   r_char_ticks  <= i_cfg_data[TICK_W-1:0];
                    REG_SPACE:  r_space_ticks <= i_cfg_data[TICK_W-1:0];
                    REG_END:    r_end_ticks   <= i_cfg_data[TICK_W-1:0];
                    REG_LOOP:   r_loop_enable <= i_cfg_data[0];
                    REG_FLASH: begin
                        r_flash_enable <= i_cfg_data[0];
                        r_flash_pin    <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_item2.cmd == CMD_WRITE && widx_ok) begin
            r_store[POS_W'(r_item2.entry_index)] <= r_item2.symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_interval <= n_interval;
        end
    end

    assign o_out_valid     = r_v3;
    assign o_segments_n    = r_segment_pins;
    assign o_flash_out     = r_flash_pin;
    assign o_next_interval = r_interval;
    assign o_string_active = r_string_mode;
    assign o_shown_symbol  = r_display_on ? r_current_symbol : SYM_BLANK;

endmodule
